// ===== src/svs_pkg.sv =====
// Shared constants, types and helper functions for the staggered grid velocity splat.
`timescale 1ns / 1ps
package svs_pkg;

	localparam int MAX_DIM    = 32;
	localparam int FRAC_BITS  = 12;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int CFG_DIM_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;
	localparam int POS_W      = 24;
	localparam int INV_W      = 24;
	localparam int VEL_W      = 24;
	localparam int NODE_W     = 5;
	localparam int G_SHIFT    = 28 - FRAC_BITS;
	localparam int G_W        = POS_W + INV_W - G_SHIFT;
	localparam int FR_W       = FRAC_BITS + 1;
	localparam int W_W        = FR_W;
	localparam int P01_W      = 2 * FR_W;
	localparam int P_W        = 3 * FR_W;
	localparam int VSUM_W     = 48;
	localparam int WSUM_W     = 24;
	localparam int CON_W      = W_W + 1 + VEL_W;
	localparam int NODE_COUNT = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int ADDR_W     = $clog2(NODE_COUNT);
	localparam int Q_DEPTH    = 4;
	localparam int Q_AW       = $clog2(Q_DEPTH);
	localparam int CORNERS    = 8;
	localparam int CNT_W      = $clog2(CORNERS + 1);
	localparam int DIV_CNT_W  = $clog2(VSUM_W + 1);

	localparam logic [FR_W-1:0] ONE_F  = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [FR_W-1:0] HALF_F = ONE_F >> 1;

	localparam logic [CFG_DIM_W-1:0]  DIM_RST = CFG_DIM_W'(32);
	localparam logic [CFG_DATA_W-1:0] INV_RST = CFG_DATA_W'(65536);

	localparam logic REQ_READ = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIM_X       = 2'd0,
		CFG_DIM_Y       = 2'd1,
		CFG_DIM_Z       = 2'd2,
		CFG_INV_SPACING = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [DIM_W-1:0] base;
		logic [FR_W-1:0]  frac;
	} axis_t;

	typedef axis_t [2:0] place_t;

	typedef logic [2:0][DIM_W-1:0] last_t;

	typedef struct packed {
		logic                    is_read;
		logic                    node_ok;
		place_t [2:0]            place;
		logic [2:0][VEL_W-1:0]   vel;
	} job_t;

	typedef struct packed {
		logic              start;
		logic              is_read;
		logic              node_ok;
		logic              clr_en;
		logic [ADDR_W-1:0] clr_addr;
	} lane_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             covered;
		logic [VEL_W-1:0] q;
	} lane_sts_t;

	// Flat node address from three node indices.
	function automatic logic [ADDR_W-1:0] node_addr(input logic [DIM_W-1:0] x,
			input logic [DIM_W-1:0] y, input logic [DIM_W-1:0] z);
		node_addr = ADDR_W'((int'(x) * MAX_DIM + int'(y)) * MAX_DIM + int'(z));
	endfunction

	// Last usable node index for a dimension register, dimension saturated to 1..MAX_DIM.
	function automatic logic [DIM_W-1:0] last_idx(input logic [CFG_DIM_W-1:0] d);
		if (d == '0) begin
			last_idx = '0;
		end else if (int'(d) > MAX_DIM) begin
			last_idx = DIM_W'(MAX_DIM - 1);
		end else begin
			last_idx = DIM_W'(int'(d) - 1);
		end
	endfunction

endpackage

// ===== src/svs_front.sv =====
// Front end: takes transactions, scales positions to grid units, finds base nodes and fractions.
`timescale 1ns / 1ps
module svs_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               req_type,
	input  logic [svs_pkg::POS_W-1:0]          pos_x,
	input  logic [svs_pkg::POS_W-1:0]          pos_y,
	input  logic [svs_pkg::POS_W-1:0]          pos_z,
	input  logic signed [svs_pkg::VEL_W-1:0]   part_vel_x,
	input  logic signed [svs_pkg::VEL_W-1:0]   part_vel_y,
	input  logic signed [svs_pkg::VEL_W-1:0]   part_vel_z,
	input  logic                               skip_particle,
	input  logic [svs_pkg::NODE_W-1:0]         node_x,
	input  logic [svs_pkg::NODE_W-1:0]         node_y,
	input  logic [svs_pkg::NODE_W-1:0]         node_z,
	input  logic [svs_pkg::INV_W-1:0]          inv_spacing,
	input  svs_pkg::last_t                     last,
	input  logic                               clearing,
	input  logic                               q_full,
	output logic                               push,
	output svs_pkg::job_t                      push_job
);

	localparam int PROD_W = svs_pkg::POS_W + svs_pkg::INV_W;

	logic                                    accept;
	logic                                    v_s1_q;
	logic                                    is_read_s1;
	logic [2:0][svs_pkg::G_W-1:0]            g_s1;
	logic [2:0][svs_pkg::VEL_W-1:0]          vel_s1;
	logic [2:0][svs_pkg::NODE_W-1:0]         node_s1;
	logic [2:0][svs_pkg::POS_W-1:0]          pos_in;

	// Base node and fraction on one axis; half moves the sample point back half a cell.
	function automatic svs_pkg::axis_t place_axis(input logic [svs_pkg::G_W-1:0] g,
			input logic half, input logic [svs_pkg::DIM_W-1:0] lim);
		logic [svs_pkg::G_W+1:0]        offv;
		logic signed [svs_pkg::G_W+1:0] t;
		logic signed [svs_pkg::G_W+1:0] org;
		logic signed [svs_pkg::G_W+1:0] f;
		logic [svs_pkg::G_W-1:0]        idx_raw;
		logic [svs_pkg::DIM_W-1:0]      idx;
		offv = half ? (svs_pkg::G_W + 2)'(svs_pkg::HALF_F) : '0;
		t = $signed({2'b00, g}) - $signed(offv);
		if (t < 0) begin
			idx = '0;
		end else begin
			idx_raw = t[svs_pkg::G_W-1:0] >> svs_pkg::FRAC_BITS;
			idx = (idx_raw > svs_pkg::G_W'(lim)) ? lim : svs_pkg::DIM_W'(idx_raw);
		end
		org = $signed(((svs_pkg::G_W + 2)'(idx) << svs_pkg::FRAC_BITS) + offv);
		f = $signed({2'b00, g}) - org;
		place_axis.base = idx;
		if (f < 0) begin
			place_axis.frac = '0;
		end else if (f > $signed((svs_pkg::G_W + 2)'(svs_pkg::ONE_F))) begin
			place_axis.frac = svs_pkg::ONE_F;
		end else begin
			place_axis.frac = svs_pkg::FR_W'(f);
		end
	endfunction

	assign in_stall = clearing | (v_s1_q & q_full);
	assign accept   = in_valid & ~in_stall;
	assign push     = v_s1_q & ~q_full;
	assign pos_in   = {pos_z, pos_y, pos_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else if (accept) begin
			// skipped particles die here
			v_s1_q <= (req_type == svs_pkg::REQ_READ) | ~skip_particle;
		end else if (push) begin
			v_s1_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			is_read_s1 <= (req_type == svs_pkg::REQ_READ);
			for (int a = 0; a < 3; a++) begin
				g_s1[a] <= svs_pkg::G_W'((PROD_W'(pos_in[a]) * PROD_W'(inv_spacing))
					>> svs_pkg::G_SHIFT);
			end
			vel_s1  <= {part_vel_z, part_vel_y, part_vel_x};
			node_s1 <= {node_z, node_y, node_x};
		end
	end

	always_comb begin
		push_job.is_read = is_read_s1;
		push_job.node_ok = (int'(node_s1[0]) < svs_pkg::MAX_DIM)
			&& (int'(node_s1[1]) < svs_pkg::MAX_DIM)
			&& (int'(node_s1[2]) < svs_pkg::MAX_DIM);
		push_job.vel = vel_s1;
		for (int c = 0; c < 3; c++) begin
			for (int a = 0; a < 3; a++) begin
				if (is_read_s1) begin
					push_job.place[c][a].base = svs_pkg::DIM_W'(node_s1[a]);
					push_job.place[c][a].frac = '0;
				end else begin
					push_job.place[c][a] = place_axis(g_s1[a], a != c, last[a]);
				end
			end
		end
	end

endmodule

// ===== src/svs_queue.sv =====
// Short job queue between the front end and the accumulate lanes.
`timescale 1ns / 1ps
module svs_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  svs_pkg::job_t push_job,
	input  logic          pop,
	output svs_pkg::job_t head,
	output logic          empty,
	output logic          full
);

	svs_pkg::job_t               slot_q [svs_pkg::Q_DEPTH];
	logic [svs_pkg::Q_AW-1:0]    wr_ptr_q;
	logic [svs_pkg::Q_AW-1:0]    rd_ptr_q;
	logic [svs_pkg::Q_AW:0]      count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (svs_pkg::Q_AW + 1)'(svs_pkg::Q_DEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// ===== src/svs_lane.sv =====
// One velocity component: node memory, eight-corner accumulate pipeline, readout divider.
`timescale 1ns / 1ps
module svs_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  svs_pkg::lane_ctl_t               ctl,
	input  svs_pkg::place_t                  place,
	input  logic signed [svs_pkg::VEL_W-1:0] vel,
	input  svs_pkg::last_t                   last,
	output svs_pkg::lane_sts_t               sts
);

	typedef enum logic [4:0] {
		L_IDLE  = 5'b00001,
		L_SPLAT = 5'b00010,
		L_RADDR = 5'b00100,
		L_RDATA = 5'b01000,
		L_DIV   = 5'b10000
	} lane_state_t;

	localparam logic [svs_pkg::VSUM_W-1:0] POS_LIM = svs_pkg::VSUM_W'((1 << (svs_pkg::VEL_W - 1)) - 1);
	localparam logic [svs_pkg::VSUM_W-1:0] NEG_LIM = svs_pkg::VSUM_W'(1 << (svs_pkg::VEL_W - 1));

	lane_state_t                              state_q;
	svs_pkg::place_t                          place_q;
	logic signed [svs_pkg::VEL_W-1:0]         vel_q;
	logic                                     node_ok_q;
	logic [svs_pkg::CNT_W-1:0]                cnt_q;

	logic [svs_pkg::VSUM_W-1:0]               vel_mem [svs_pkg::NODE_COUNT];
	logic [svs_pkg::WSUM_W-1:0]               w_mem   [svs_pkg::NODE_COUNT];

	logic                                     issue;
	logic [2:0]                               corner;
	logic [2:0][svs_pkg::DIM_W-1:0]           n;
	logic [2:0][svs_pkg::FR_W-1:0]            fsel;
	logic                                     ok;
	logic [svs_pkg::ADDR_W-1:0]               base_addr;
	logic [svs_pkg::ADDR_W-1:0]               rd_addr;

	logic                                     v_s1, v_s2, v_s3;
	logic                                     ok_s1, ok_s2, ok_s3;
	logic [svs_pkg::ADDR_W-1:0]               addr_s1, addr_s2, addr_s3;
	logic [svs_pkg::P01_W-1:0]                p01_s1;
	logic [svs_pkg::FR_W-1:0]                 fc_s1;
	logic [svs_pkg::W_W-1:0]                  w_s2, w_s3;
	logic signed [svs_pkg::CON_W-1:0]         con_s3;
	logic [svs_pkg::VSUM_W-1:0]               rdv_s1, rdv_s2, rdv_s3;
	logic [svs_pkg::WSUM_W-1:0]               rdw_s1, rdw_s2, rdw_s3;
	logic [svs_pkg::P_W-1:0]                  p_full;

	logic signed [svs_pkg::VSUM_W:0]          vsum;
	logic [svs_pkg::WSUM_W:0]                 wsum;
	logic [svs_pkg::VSUM_W-1:0]               vsum_sat;
	logic [svs_pkg::WSUM_W-1:0]               wsum_sat;

	logic                                     mem_we;
	logic [svs_pkg::ADDR_W-1:0]               mem_wa;
	logic [svs_pkg::VSUM_W-1:0]               mem_wdv;
	logic [svs_pkg::WSUM_W-1:0]               mem_wdw;

	logic [svs_pkg::VSUM_W-1:0]               quo_q;
	logic [svs_pkg::WSUM_W-1:0]               rem_q;
	logic [svs_pkg::WSUM_W-1:0]               dvs_q;
	logic                                     neg_q;
	logic [svs_pkg::DIV_CNT_W-1:0]            div_cnt_q;
	logic [svs_pkg::WSUM_W:0]                 trial;
	logic                                     qbit;
	logic [svs_pkg::VEL_W-1:0]                q_q;
	logic                                     covered_q;

	// corner generation
	assign issue  = (state_q == L_SPLAT) && (cnt_q < svs_pkg::CNT_W'(svs_pkg::CORNERS));
	assign corner = cnt_q[2:0];

	always_comb begin
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			n[a] = place_q[a].base + svs_pkg::DIM_W'(corner[a]);
			if (corner[a] && (place_q[a].base >= last[a])) begin
				ok = 1'b0;
			end
			fsel[a] = corner[a] ? place_q[a].frac : svs_pkg::ONE_F - place_q[a].frac;
		end
	end

	assign base_addr = svs_pkg::node_addr(place_q[0].base, place_q[1].base, place_q[2].base);
	assign rd_addr   = (state_q == L_SPLAT) ? svs_pkg::node_addr(n[0], n[1], n[2]) : base_addr;

	// accumulate at the end of stage 3
	assign p_full = svs_pkg::P_W'(p01_s1) * svs_pkg::P_W'(fc_s1);

	always_comb begin
		vsum = $signed({rdv_s3[svs_pkg::VSUM_W-1], rdv_s3}) + (svs_pkg::VSUM_W + 1)'(con_s3);
		if (vsum[svs_pkg::VSUM_W] != vsum[svs_pkg::VSUM_W-1]) begin
			vsum_sat = vsum[svs_pkg::VSUM_W] ? {1'b1, {(svs_pkg::VSUM_W-1){1'b0}}}
				: {1'b0, {(svs_pkg::VSUM_W-1){1'b1}}};
		end else begin
			vsum_sat = vsum[svs_pkg::VSUM_W-1:0];
		end
		wsum = {1'b0, rdw_s3} + (svs_pkg::WSUM_W + 1)'(w_s3);
		wsum_sat = wsum[svs_pkg::WSUM_W] ? '1 : wsum[svs_pkg::WSUM_W-1:0];
	end

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = addr_s3;
		mem_wdv = vsum_sat;
		mem_wdw = wsum_sat;
		if (ctl.clr_en) begin
			mem_we  = 1'b1;
			mem_wa  = ctl.clr_addr;
			mem_wdv = '0;
			mem_wdw = '0;
		end else if (state_q == L_RDATA) begin
			mem_we  = node_ok_q;
			mem_wa  = base_addr;
			mem_wdv = '0;
			mem_wdw = '0;
		end else if (v_s3 && ok_s3) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		rdv_s1 <= vel_mem[rd_addr];
		rdw_s1 <= w_mem[rd_addr];
		if (mem_we) begin
			vel_mem[mem_wa] <= mem_wdv;
			w_mem[mem_wa]   <= mem_wdw;
		end
	end

	// corner pipeline payload
	always_ff @(posedge clk) begin
		ok_s1   <= ok;
		addr_s1 <= rd_addr;
		p01_s1  <= svs_pkg::P01_W'(fsel[0]) * svs_pkg::P01_W'(fsel[1]);
		fc_s1   <= fsel[2];
		ok_s2   <= ok_s1;
		addr_s2 <= addr_s1;
		w_s2    <= svs_pkg::W_W'(p_full >> (2 * svs_pkg::FRAC_BITS));
		rdv_s2  <= rdv_s1;
		rdw_s2  <= rdw_s1;
		ok_s3   <= ok_s2;
		addr_s3 <= addr_s2;
		w_s3    <= w_s2;
		con_s3  <= $signed({1'b0, w_s2}) * vel_q;
		rdv_s3  <= rdv_s2;
		rdw_s3  <= rdw_s2;
		if (ctl.start) begin
			place_q   <= place;
			vel_q     <= vel;
			node_ok_q <= ctl.node_ok;
		end
	end

	// restoring divide, one quotient bit per cycle
	assign trial = {rem_q, quo_q[svs_pkg::VSUM_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= L_IDLE;
			cnt_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			div_cnt_q <= '0;
			covered_q <= 1'b0;
			q_q       <= '0;
			quo_q     <= '0;
			rem_q     <= '0;
			dvs_q     <= '0;
			neg_q     <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			unique case (state_q)
				L_IDLE: begin
					if (ctl.start) begin
						cnt_q   <= '0;
						state_q <= ctl.is_read ? L_RADDR : L_SPLAT;
					end
				end
				L_SPLAT: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s1 && !v_s2 && !v_s3) begin
						state_q <= L_IDLE;
					end
				end
				L_RADDR: begin
					state_q <= L_RDATA;
				end
				L_RDATA: begin
					if (!node_ok_q || rdw_s1 == '0) begin
						q_q       <= '0;
						covered_q <= 1'b0;
						state_q   <= L_IDLE;
					end else begin
						neg_q     <= rdv_s1[svs_pkg::VSUM_W-1];
						quo_q     <= rdv_s1[svs_pkg::VSUM_W-1] ? -rdv_s1 : rdv_s1;
						rem_q     <= '0;
						dvs_q     <= rdw_s1;
						div_cnt_q <= svs_pkg::DIV_CNT_W'(svs_pkg::VSUM_W);
						state_q   <= L_DIV;
					end
				end
				L_DIV: begin
					if (div_cnt_q != '0) begin
						rem_q     <= qbit ? svs_pkg::WSUM_W'(trial - {1'b0, dvs_q})
							: trial[svs_pkg::WSUM_W-1:0];
						quo_q     <= {quo_q[svs_pkg::VSUM_W-2:0], qbit};
						div_cnt_q <= div_cnt_q - 1'b1;
					end else begin
						covered_q <= 1'b1;
						if (!neg_q) begin
							q_q <= (quo_q > POS_LIM) ? POS_LIM[svs_pkg::VEL_W-1:0]
								: quo_q[svs_pkg::VEL_W-1:0];
						end else begin
							q_q <= (quo_q > NEG_LIM) ? NEG_LIM[svs_pkg::VEL_W-1:0]
								: -quo_q[svs_pkg::VEL_W-1:0];
						end
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	assign sts.busy    = (state_q != L_IDLE);
	assign sts.covered = covered_q;
	assign sts.q       = q_q;

endmodule

// ===== src/staggered_grid_velocity_splat.sv =====
// Top level: config registers, clearing sweep, job dispatch to three lanes, result register.
`timescale 1ns / 1ps
// Splat: front stage, queue, then the lanes (start, eight corner read-modify-writes through
//   the node memory port, three-stage drain).
// Readout: address, read data, 48-step divider, finalize; the result goes to the output register
//   once all lanes finish; if nothing is covered the lane skips the divider.
// Queue of four jobs decouples front and lanes; results sit in an output register.
// Reset: async, active low; then a clearing sweep over all 32768 nodes zeroes node memory,
//   in_stall held high meanwhile (config writes still taken).
module staggered_grid_velocity_splat (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [svs_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [svs_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic                                  req_type,
	input  logic [svs_pkg::POS_W-1:0]             pos_x,
	input  logic [svs_pkg::POS_W-1:0]             pos_y,
	input  logic [svs_pkg::POS_W-1:0]             pos_z,
	input  logic signed [svs_pkg::VEL_W-1:0]      part_vel_x,
	input  logic signed [svs_pkg::VEL_W-1:0]      part_vel_y,
	input  logic signed [svs_pkg::VEL_W-1:0]      part_vel_z,
	input  logic                                  skip_particle,
	input  logic [svs_pkg::NODE_W-1:0]            node_x,
	input  logic [svs_pkg::NODE_W-1:0]            node_y,
	input  logic [svs_pkg::NODE_W-1:0]            node_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [svs_pkg::VEL_W-1:0]      grid_vel_x,
	output logic signed [svs_pkg::VEL_W-1:0]      grid_vel_y,
	output logic signed [svs_pkg::VEL_W-1:0]      grid_vel_z,
	output logic [2:0]                            covered_mask
);

	// config registers
	logic [svs_pkg::CFG_DIM_W-1:0]   dim_x_q, dim_y_q, dim_z_q;
	logic [svs_pkg::INV_W-1:0]       inv_spacing_q;
	svs_pkg::last_t                  last;

	// clearing sweep
	logic                            clr_busy_q;
	logic [svs_pkg::ADDR_W-1:0]      clr_addr_q;

	// front / queue / lanes
	logic                            push;
	svs_pkg::job_t                   push_job;
	svs_pkg::job_t                   head;
	logic                            q_empty, q_full;
	logic                            pop;
	logic                            any_busy;
	logic                            rd_pend_q;
	logic                            rd_done;
	svs_pkg::lane_ctl_t              ctl;
	svs_pkg::lane_sts_t [2:0]        sts;

	// result register
	logic                            out_valid_q;
	logic [2:0][svs_pkg::VEL_W-1:0]  gv_q;
	logic [2:0]                      mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_x_q       <= svs_pkg::DIM_RST;
			dim_y_q       <= svs_pkg::DIM_RST;
			dim_z_q       <= svs_pkg::DIM_RST;
			inv_spacing_q <= svs_pkg::INV_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				svs_pkg::CFG_DIM_X:       dim_x_q <= cfg_wdata[svs_pkg::CFG_DIM_W-1:0];
				svs_pkg::CFG_DIM_Y:       dim_y_q <= cfg_wdata[svs_pkg::CFG_DIM_W-1:0];
				svs_pkg::CFG_DIM_Z:       dim_z_q <= cfg_wdata[svs_pkg::CFG_DIM_W-1:0];
				svs_pkg::CFG_INV_SPACING: inv_spacing_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// dims saturated to 1..MAX_DIM, kept as last valid index
	assign last[0] = svs_pkg::last_idx(dim_x_q);
	assign last[1] = svs_pkg::last_idx(dim_y_q);
	assign last[2] = svs_pkg::last_idx(dim_z_q);

	// one node per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == svs_pkg::ADDR_W'(svs_pkg::NODE_COUNT - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	svs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.req_type      (req_type),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.pos_z         (pos_z),
		.part_vel_x    (part_vel_x),
		.part_vel_y    (part_vel_y),
		.part_vel_z    (part_vel_z),
		.skip_particle (skip_particle),
		.node_x        (node_x),
		.node_y        (node_y),
		.node_z        (node_z),
		.inv_spacing   (inv_spacing_q),
		.last          (last),
		.clearing      (clr_busy_q),
		.q_full        (q_full),
		.push          (push),
		.push_job      (push_job)
	);

	svs_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	// Lanes start together; a readout lane with nothing covered finishes early.
	// The next job waits for all three; a readout waits for a free result register.
	assign any_busy = sts[0].busy | sts[1].busy | sts[2].busy;
	assign pop = !q_empty && !clr_busy_q && !any_busy && !rd_pend_q
		&& (!head.is_read || !out_valid_q);
	assign rd_done = rd_pend_q && !any_busy;

	assign ctl.start    = pop;
	assign ctl.is_read  = head.is_read;
	assign ctl.node_ok  = head.node_ok;
	assign ctl.clr_en   = clr_busy_q;
	assign ctl.clr_addr = clr_addr_q;

	for (genvar c = 0; c < 3; c++) begin : g_lane
		svs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.place  (head.place[c]),
			.vel    ($signed(head.vel[c])),
			.last   (last),
			.sts    (sts[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head.is_read) begin
				rd_pend_q <= 1'b1;
			end else if (rd_done) begin
				rd_pend_q <= 1'b0;
			end
			if (rd_done) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_done) begin
			for (int c = 0; c < 3; c++) begin
				gv_q[c]   <= sts[c].q;
				mask_q[c] <= sts[c].covered;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign grid_vel_x   = $signed(gv_q[0]);
	assign grid_vel_y   = $signed(gv_q[1]);
	assign grid_vel_z   = $signed(gv_q[2]);
	assign covered_mask = mask_q;

	// no job leaves the queue during the clearing sweep
	a_no_pop_clr: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !pop)
		else $error("job dispatched during clearing sweep");

	// a readout result never overwrites a result that has not yet been taken
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		rd_done |-> !out_valid_q)
		else $error("result register overwritten");

	// all three lanes take a dispatched job
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (sts[0].busy && sts[1].busy && sts[2].busy))
		else $error("lanes out of step");

	// a dispatched job keeps the lanes busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> any_busy)
		else $error("lanes did not take job");

endmodule

// ===== test/splat_checker.sv =====
// Watches the splat block's channels, predicts readout results and compares them.
`timescale 1ns / 1ps
module splat_checker
	import svs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic                     req_type,
	input  logic [POS_W-1:0]         pos_x,
	input  logic [POS_W-1:0]         pos_y,
	input  logic [POS_W-1:0]         pos_z,
	input  logic signed [VEL_W-1:0]  part_vel_x,
	input  logic signed [VEL_W-1:0]  part_vel_y,
	input  logic signed [VEL_W-1:0]  part_vel_z,
	input  logic                     skip_particle,
	input  logic [NODE_W-1:0]        node_x,
	input  logic [NODE_W-1:0]        node_y,
	input  logic [NODE_W-1:0]        node_z,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic signed [VEL_W-1:0]  grid_vel_x,
	input  logic signed [VEL_W-1:0]  grid_vel_y,
	input  logic signed [VEL_W-1:0]  grid_vel_z,
	input  logic [2:0]               covered_mask,
	output int                       errors,
	output int                       pending
);

	typedef struct {
		logic signed [VEL_W-1:0] vel [3];
		logic [2:0]              mask;
	} face_vel_t;

	localparam longint ONE  = 64'sd1 <<< FRAC_BITS;
	localparam longint HALF = 64'sd1 <<< (FRAC_BITS - 1);
	localparam longint VSUM_MAX = (64'sd1 <<< 47) - 1;
	localparam longint VSUM_MIN = -(64'sd1 <<< 47);

	logic [CFG_DIM_W-1:0]  dim_reg [3];
	logic [CFG_DATA_W-1:0] spacing_inv;
	longint                vel_acc [NODE_COUNT*3];
	longint                wt_acc  [NODE_COUNT*3];
	face_vel_t             readout_q [$];

	function automatic longint used_dim(input logic [CFG_DIM_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM) return MAX_DIM;
		return longint'(d);
	endfunction

	function automatic void accumulate(input int slot, input longint w, input longint v);
		longint s;
		longint ws;
		s  = vel_acc[slot] + w * v;
		ws = wt_acc[slot] + w;
		if (s > VSUM_MAX) s = VSUM_MAX;
		if (s < VSUM_MIN) s = VSUM_MIN;
		if (ws > 64'hFFFFFF) ws = 64'hFFFFFF;
		vel_acc[slot] = s;
		wt_acc[slot]  = ws;
	endfunction

	// One velocity component onto its staggered face grid.
	function automatic void splat_face(input int c, input longint g [3], input longint dims [3],
			input longint v);
		longint base [3];
		longint fr [3];
		longint off, t, idx, f, prod;
		longint n [3];
		bit ok, up;
		for (int a = 0; a < 3; a++) begin
			off = (a == c) ? 0 : HALF;
			t   = g[a] - off;
			idx = (t >= 0) ? (t >>> FRAC_BITS) : -1;
			if (idx < 0) idx = 0;
			if (idx > dims[a] - 1) idx = dims[a] - 1;
			f = g[a] - (idx * ONE + off);
			if (f < 0) f = 0;
			if (f > ONE) f = ONE;
			base[a] = idx;
			fr[a]   = f;
		end
		for (int k = 0; k < 8; k++) begin
			prod = 1;
			ok   = 1;
			for (int a = 0; a < 3; a++) begin
				up = k[a];
				if (up && base[a] >= dims[a] - 1) ok = 0;
				n[a] = base[a] + up;
				prod = prod * (up ? fr[a] : ONE - fr[a]);
			end
			if (ok)
				accumulate(int'(((n[0] * MAX_DIM + n[1]) * MAX_DIM + n[2]) * 3 + c),
					prod >>> (2 * FRAC_BITS), v);
		end
	endfunction

	function automatic face_vel_t read_and_clear(input int nx, input int ny, input int nz);
		face_vel_t r;
		int        slot;
		longint    q;
		r.mask = '0;
		for (int c = 0; c < 3; c++) begin
			slot = ((nx * MAX_DIM + ny) * MAX_DIM + nz) * 3 + c;
			q = 0;
			if (wt_acc[slot] > 0) begin
				q = vel_acc[slot] / wt_acc[slot];
				if (q > 8388607) q = 8388607;
				if (q < -8388608) q = -8388608;
				r.mask[c] = 1'b1;
			end
			r.vel[c] = q[VEL_W-1:0];
			vel_acc[slot] = 0;
			wt_acc[slot]  = 0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		longint    g [3];
		longint    dims [3];
		face_vel_t exp_r;
		logic signed [VEL_W-1:0] got [3];
		if (!arst_n) begin
			dim_reg     = '{DIM_RST, DIM_RST, DIM_RST};
			spacing_inv = INV_RST;
			foreach (vel_acc[i]) begin
				vel_acc[i] = 0;
				wt_acc[i]  = 0;
			end
			readout_q.delete();
			errors  = 0;
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_DIM_X:       dim_reg[0] = cfg_wdata[CFG_DIM_W-1:0];
					CFG_DIM_Y:       dim_reg[1] = cfg_wdata[CFG_DIM_W-1:0];
					CFG_DIM_Z:       dim_reg[2] = cfg_wdata[CFG_DIM_W-1:0];
					CFG_INV_SPACING: spacing_inv = cfg_wdata;
				endcase
			end
			if (out_valid && !out_stall) begin
				got = '{grid_vel_x, grid_vel_y, grid_vel_z};
				if (readout_q.size() == 0) begin
					$display("%0t: unexpected result vel %h %h %h mask %b", $time,
						got[0], got[1], got[2], covered_mask);
					errors++;
				end else begin
					exp_r = readout_q.pop_front();
					for (int c = 0; c < 3; c++)
						if (got[c] !== exp_r.vel[c]) begin
							$display("%0t: grid_vel[%0d] expected %h actual %h", $time, c,
								exp_r.vel[c], got[c]);
							errors++;
						end
					if (covered_mask !== exp_r.mask) begin
						$display("%0t: covered_mask expected %b actual %b", $time,
							exp_r.mask, covered_mask);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (req_type == REQ_READ) begin
					readout_q.push_back(read_and_clear(node_x, node_y, node_z));
				end else if (!skip_particle) begin
					g[0] = (longint'(pos_x) * spacing_inv) >>> G_SHIFT;
					g[1] = (longint'(pos_y) * spacing_inv) >>> G_SHIFT;
					g[2] = (longint'(pos_z) * spacing_inv) >>> G_SHIFT;
					for (int a = 0; a < 3; a++) dims[a] = used_dim(dim_reg[a]);
					splat_face(0, g, dims, longint'(part_vel_x));
					splat_face(1, g, dims, longint'(part_vel_y));
					splat_face(2, g, dims, longint'(part_vel_z));
				end
			end
			pending = readout_q.size();
		end
	end

endmodule

// ===== test/tb.sv =====
// Testbench top for the staggered grid velocity splat: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb;
	import svs_pkg::*;

	// Slowest run is the clearing sweep plus ~600 transactions.
	localparam int CYCLE_LIMIT = 1000000;
	localparam int LONG_HOLD   = 400;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_wdata;
	logic                    in_valid;
	logic                    in_stall;
	logic                    req_type;
	logic [POS_W-1:0]        pos_x, pos_y, pos_z;
	logic signed [VEL_W-1:0] part_vel_x, part_vel_y, part_vel_z;
	logic                    skip_particle;
	logic [NODE_W-1:0]       node_x, node_y, node_z;
	logic                    out_valid;
	logic                    out_stall;
	logic signed [VEL_W-1:0] grid_vel_x, grid_vel_y, grid_vel_z;
	logic [2:0]              covered_mask;

	int errors;
	int pending;
	int cycles = 0;
	bit calm;       // last stretch: no idling on either side
	bit hold_req;   // ask the receiver for one long hold-off
	bit hold_done;

	// Settings walked through by the random part: dims and inverse spacing.
	int phase_dim [7][3] = '{'{32, 32, 32}, '{2, 2, 2}, '{0, 63, 5}, '{7, 32, 3},
		'{32, 2, 17}, '{13, 9, 32}, '{32, 32, 32}};
	int phase_inv [7] = '{65536, 16777215, 65536, 1, 0, 131072, 32768};
	int cur_dim [3];
	int cur_inv;
	logic [POS_W-1:0] last_pos [3];

	staggered_grid_velocity_splat dut (.*);

	splat_checker chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off on request, quiet at the end.
	initial begin
		int n;
		out_stall = 0;
		hold_done = 0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done = 1;
				out_stall <= 1;
				repeat (LONG_HOLD) @(posedge clk);
				out_stall <= 0;
			end else if (!calm && $urandom_range(0, 9) < 2) begin
				n = $urandom_range(1, 18);
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	task automatic write_cfg(input int dx, input int dy, input int dz, input int inv);
		cfg_idx_t idx [4] = '{CFG_DIM_X, CFG_DIM_Y, CFG_DIM_Z, CFG_INV_SPACING};
		int       val [4];
		val = '{dx, dy, dz, inv};
		for (int i = 0; i < 4; i++) begin
			cfg_we    <= 1;
			cfg_index <= idx[i];
			cfg_wdata <= CFG_DATA_W'(val[i]);
			@(posedge clk);
		end
		cfg_we <= 0;
		cur_dim = '{dx, dy, dz};
		cur_inv = inv;
	endtask

	// Offer one transaction, with an optional random gap ahead of it, and wait for acceptance.
	task automatic send(input logic rt, input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
			input logic [VEL_W-1:0] vz, input logic sk, input logic [NODE_W-1:0] nx,
			input logic [NODE_W-1:0] ny, input logic [NODE_W-1:0] nz);
		if (!calm && $urandom_range(0, 9) < 2) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid      <= 1;
		req_type      <= rt;
		pos_x         <= px;
		pos_y         <= py;
		pos_z         <= pz;
		part_vel_x    <= vx;
		part_vel_y    <= vy;
		part_vel_z    <= vz;
		skip_particle <= sk;
		node_x        <= nx;
		node_y        <= ny;
		node_z        <= nz;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic splat(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
			input logic [POS_W-1:0] pz, input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy,
			input logic [VEL_W-1:0] vz, input logic sk);
		send(1'b0, px, py, pz, vx, vy, vz, sk, NODE_W'($urandom), NODE_W'($urandom),
			NODE_W'($urandom));
	endtask

	task automatic readout(input int nx, input int ny, input int nz);
		send(REQ_READ, POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
			VEL_W'($urandom), VEL_W'($urandom), VEL_W'($urandom), 1'($urandom),
			NODE_W'(nx), NODE_W'(ny), NODE_W'(nz));
	endtask

	// Drain: wait for every readout, then let in-flight splats settle.
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	// Position that lands mostly on or just around the grid in use.
	function automatic logic [POS_W-1:0] near_pos(input int a);
		longint span;
		if ($urandom_range(0, 9) == 0 || cur_inv == 0) return POS_W'($urandom);
		span = ((longint'(cur_dim[a] == 0 ? 1 : cur_dim[a]) + 1) << 28) / cur_inv;
		if (span > 24'hFFFFFF) span = 24'hFFFFFF;
		return POS_W'($urandom_range(0, int'(span)));
	endfunction

	// Node near the last splatted particle, so readouts mostly hit covered nodes.
	function automatic int near_node(input int a);
		longint n;
		n = ((longint'(last_pos[a]) * cur_inv) >> G_SHIFT) >> FRAC_BITS;
		n = n + $urandom_range(0, 2) - 1;
		if (n < 0) n = 0;
		if (n > 31) n = 31;
		return int'(n);
	endfunction

	initial begin
		int pick;
		arst_n        = 0;
		cfg_we        = 0;
		cfg_index     = CFG_DIM_X;
		cfg_wdata     = '0;
		in_valid      = 0;
		req_type      = 0;
		pos_x         = '0;
		pos_y         = '0;
		pos_z         = '0;
		part_vel_x    = '0;
		part_vel_y    = '0;
		part_vel_z    = '0;
		skip_particle = 0;
		node_x        = '0;
		node_y        = '0;
		node_z        = '0;
		calm          = 0;
		hold_req      = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: below/above grid, velocity extremes, skip, uncovered and corner nodes.
		write_cfg(32, 32, 32, 65536);
		splat(24'h000000, 24'h000000, 24'h000000, 24'h7FFFFF, 24'h800000, 24'h000001, 0);
		splat(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hFFFFFF, 0);
		splat(24'h001800, 24'h002400, 24'h003C00, 24'h001000, 24'hFFF000, 24'h000800, 0);
		splat(24'h001800, 24'h002400, 24'h003C00, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 0);
		splat(24'h005000, 24'h005000, 24'h005000, 24'h123456, 24'h654321, 24'h0ABCDE, 1);
		splat(24'h01F000, 24'h01F800, 24'h01FFFF, 24'h7FFFFF, 24'h800000, 24'h400000, 0);
		readout(0, 0, 0);
		readout(0, 0, 0);
		readout(31, 31, 31);
		readout(1, 2, 3);
		readout(1, 1, 3);
		readout(2, 2, 4);
		readout(5, 5, 5);
		readout(31, 30, 31);
		readout(30, 31, 31);
		drain();
		write_cfg(2, 2, 2, 16777215);
		splat(24'h000800, 24'h000400, 24'h000C00, 24'h7FFFFF, 24'h800000, 24'h000100, 0);
		splat(24'hFFFFFF, 24'h000000, 24'h000001, 24'h000100, 24'h000200, 24'h000300, 0);
		readout(0, 0, 0);
		readout(1, 1, 1);
		readout(1, 0, 0);
		drain();

		// Random phases over several settings; the last one runs without idling.
		for (int p = 0; p < 7; p++) begin
			write_cfg(phase_dim[p][0], phase_dim[p][1], phase_dim[p][2], phase_inv[p]);
			last_pos = '{'0, '0, '0};
			calm     = (p == 6);
			hold_req = (p == 1);
			for (int i = 0; i < 85; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65) begin
					last_pos = '{near_pos(0), near_pos(1), near_pos(2)};
					splat(last_pos[0], last_pos[1], last_pos[2], VEL_W'($urandom),
						VEL_W'($urandom), VEL_W'($urandom), 0);
				end else if (pick < 70) begin
					splat(POS_W'($urandom), POS_W'($urandom), POS_W'($urandom),
						VEL_W'($urandom), VEL_W'($urandom), VEL_W'($urandom), 1);
				end else if (pick < 92) begin
					readout(near_node(0), near_node(1), near_node(2));
				end else begin
					readout($urandom_range(0, 31), $urandom_range(0, 31),
						$urandom_range(0, 31));
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/svs_pkg.sv
src/svs_front.sv
src/svs_queue.sv
src/svs_lane.sv
src/staggered_grid_velocity_splat.sv
test/splat_checker.sv
test/tb.sv
